// ===== sv/obfa_pkg.sv =====
// ----------------------------------------------------------------------------
// obfa_pkg
// Shared types and constants for the online bin-fit allocator.
// ----------------------------------------------------------------------------
package obfa_pkg;

  // Storage geometry
  localparam int NUM_BINS  = 64;
  localparam int SIZE_BITS = 16;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int CNT_W     = $clog2(NUM_BINS + 1);

  // Fixed field widths
  localparam int ITEM_W    = 16;
  localparam int CAP_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = ((SIZE_BITS > ITEM_W) ? SIZE_BITS : ITEM_W) + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_CAPACITY = 2'd1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_NO_ROOM  = 2'd2
  } place_status_e;

  // Input item
  typedef struct packed {
    logic [ITEM_W-1:0] item_size;
    logic              new_set;
  } item_t;

  // Result item
  typedef struct packed {
    logic [5:0]    bin_index;
    place_status_e place_status;
    logic [6:0]    bins_used;
  } result_t;

endpackage

// ===== sv/online_bin_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// online_bin_fit_allocator_top
// Places items into bins by first fit or best fit; fill levels in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. The result appears
//   on result_o for exactly one cycle with done_o high; there is no back
//   pressure, the receiver must take it in that cycle.
//   Configuration writes (fit mode, bin capacity) use cfg_valid_i/cfg_ready_o
//   with cfg_ready_o always high; write only while busy is low.
//   Flow: the scan issues one read per bin from the level RAM, registers
//   each level and checks it against the item, then the result state
//   writes the level back and registers the result. An oversize item skips
//   the scan and goes straight to the result state. busy drops in the
//   cycle that shows the result, so the next item can be taken at the edge
//   that ends it; an item is not taken while the last one is in flight.
//   Reset clears the per-bin valid flags, so every bin reads empty at once;
//   there is no clearing pass. new_set clears those flags as the item is taken.
//   Registers reset to first fit and capacity 100.
// ----------------------------------------------------------------------------
module online_bin_fit_allocator_top
  import obfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item_i,
  output logic                 done_o,
  output result_t              result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CAP_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  localparam int SCAN_W_L = CNT_W;
  localparam logic [SCAN_W_L-1:0] SCAN_END = SCAN_W_L'(NUM_BINS);

  state_e               state_q;
  logic                 fit_mode_q;
  logic [CAP_W-1:0]     bin_cap_q;
  logic [NUM_BINS-1:0]  valid_q;
  logic [CNT_W-1:0]     used_q;
  logic [SCAN_W_L-1:0]  scan_q;
  logic                 chk_vld_q;
  logic [BIN_W-1:0]     chk_idx_q;
  logic [ITEM_W-1:0]    size_q;
  logic                 found_q;
  logic [BIN_W-1:0]     best_idx_q;
  logic [CAP_W-1:0]     best_rem_q;
  logic [SIZE_BITS-1:0] best_lvl_q;
  place_status_e        status_q;
  logic                 done_q;
  result_t              result_q;

  // Level RAM
  logic [SIZE_BITS-1:0] level_mem [NUM_BINS];
  logic [SIZE_BITS-1:0] rd_q;
  logic [BIN_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [SIZE_BITS-1:0] wr_data;

  // Scan compare
  logic [SIZE_BITS-1:0] lvl;
  logic [SUM_W-1:0]     sum;
  logic                 fits;
  logic [CAP_W-1:0]     rem;
  logic                 take;
  logic                 bump;
  logic [CNT_W-1:0]     used_d;

  assign rd_addr = scan_q[BIN_W-1:0];
  assign wr_en   = (state_q == S_RESULT) && found_q;
  assign wr_data = SIZE_BITS'(SUM_W'(best_lvl_q) + SUM_W'(size_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      level_mem[best_idx_q] <= wr_data;
    end
    rd_q <= level_mem[rd_addr];
  end

  // A bin not written since the last clear reads as empty
  assign lvl  = valid_q[chk_idx_q] ? rd_q : '0;
  assign sum  = SUM_W'(lvl) + SUM_W'(size_q);
  assign fits = (sum <= SUM_W'(bin_cap_q));
  assign rem  = CAP_W'(SUM_W'(bin_cap_q) - sum);
  assign take = fits && (!found_q || (fit_mode_q && (rem < best_rem_q)));

  // Count a bin once it turns non-empty
  assign bump   = found_q && (best_lvl_q == '0) && (size_q != '0);
  assign used_d = bump ? used_q + CNT_W'(1) : used_q;

  // Control, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fit_mode_q <= 1'b0;
      bin_cap_q  <= CAP_W'(100);
      valid_q    <= '0;
      used_q     <= '0;
      scan_q     <= '0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      size_q     <= '0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
      best_rem_q <= '0;
      best_lvl_q <= '0;
      status_q   <= ST_PLACED;
      done_q     <= 1'b0;
      result_q   <= '0;
    end else begin
      // strobes follow the state
      done_q    <= (state_q == S_RESULT);
      chk_vld_q <= (state_q == S_SCAN) && (scan_q < SCAN_END);

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FIT_MODE:     fit_mode_q <= cfg_data_i[0];
          REG_BIN_CAPACITY: bin_cap_q  <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            size_q     <= item_i.item_size;
            found_q    <= 1'b0;
            best_rem_q <= '0;
            best_lvl_q <= '0;
            best_idx_q <= '0;
            scan_q     <= '0;
            if (item_i.new_set) begin
              valid_q <= '0;
              used_q  <= '0;
            end
            if (item_i.item_size > bin_cap_q) begin
              status_q <= ST_OVERSIZE;
              state_q  <= S_RESULT;
            end else begin
              status_q <= ST_NO_ROOM;
              state_q  <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // issue one read per cycle
          if (scan_q < SCAN_END) begin
            chk_idx_q <= rd_addr;
            scan_q    <= scan_q + SCAN_W_L'(1);
          end
          // check the level returned for the previous read
          if (chk_vld_q) begin
            if (take) begin
              found_q    <= 1'b1;
              best_idx_q <= chk_idx_q;
              best_rem_q <= rem;
              best_lvl_q <= lvl;
              status_q   <= ST_PLACED;
            end
            if (chk_idx_q == BIN_W'(NUM_BINS - 1)) begin
              state_q <= S_RESULT;
            end
          end
        end

        S_RESULT: begin
          if (found_q) begin
            valid_q[best_idx_q] <= 1'b1;
          end
          used_q                <= used_d;
          result_q.bin_index    <= found_q ? 6'(best_idx_q) : 6'd0;
          result_q.place_status <= status_q;
          result_q.bins_used    <= 7'(used_d);
          state_q               <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign result_o    = result_q;
  assign cfg_ready_o = 1'b1;

  // Checks
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without an item in flight");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("more than one result for an item");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_unplaced_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.place_status != ST_PLACED)) |-> (result_o.bin_index == 6'd0))
    else $error("bin index set on an unplaced item");

endmodule

// ===== tb/sv/online_bin_fit_allocator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// online_bin_fit_allocator_top_test
// Self-checking bench for the first-fit / best-fit bin allocator.
// A short directed run covers the corner cases. Random phases follow, each
// with a fresh fit mode and bin capacity, and send item sets of random length,
// in most phases with gaps between transfers. Every accepted item is placed
// in a local copy of the bin levels, and each result strobe is checked
// against the oldest placement still waiting.
// ----------------------------------------------------------------------------
module online_bin_fit_allocator_top_test;
  import obfa_pkg::*;

  localparam int CYCLE_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 2 * (NUM_BINS + 3);
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 100;

  // Indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Bin levels, placement prediction and result checking
  class bin_fit_checker;
    bit                 tight_fit   = 1'b0;
    bit [CAP_W-1:0]     capacity    = 16'd100;
    bit [SIZE_BITS-1:0] level [NUM_BINS];
    int                 bins_filled = 0;
    result_t            expected_q [$];
    int                 fails       = 0;

    function void report(string msg);
      fails++;
      if (fails <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
      case (idx)
        REG_FIT_MODE:     tight_fit = data[0];
        REG_BIN_CAPACITY: capacity  = data;
        default: ;
      endcase
    endfunction

    // Work out where an accepted item lands and queue the result
    function void place_item(item_t it);
      result_t        r;
      bit [SUM_W-1:0] sum;
      bit [SUM_W-1:0] rem;
      bit [SUM_W-1:0] best_rem;
      bit             found;
      int             chosen;
      found    = 1'b0;
      chosen   = 0;
      best_rem = '0;
      if (it.new_set) begin
        foreach (level[i]) level[i] = '0;
        bins_filled = 0;
      end
      if (it.item_size > capacity) begin
        r.place_status = ST_OVERSIZE;
      end else begin
        for (int i = 0; i < NUM_BINS; i++) begin
          sum = SUM_W'(level[i]) + SUM_W'(it.item_size);
          if (sum <= SUM_W'(capacity)) begin
            rem = SUM_W'(capacity) - sum;
            if (!found || (tight_fit && rem < best_rem)) begin
              found    = 1'b1;
              best_rem = rem;
              chosen   = i;
            end
            if (!tight_fit) break;
          end
        end
        if (found) begin
          // a zero-size item leaves an empty bin empty
          if (level[chosen] == '0 && it.item_size != '0) bins_filled++;
          level[chosen] = level[chosen] + it.item_size;
          r.place_status = ST_PLACED;
        end else begin
          r.place_status = ST_NO_ROOM;
        end
      end
      r.bin_index = found ? 6'(chosen) : '0;
      r.bins_used = 7'(bins_filled);
      expected_q.push_back(r);
    endfunction

    function void check_placement(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: bin %0d status %0d used %0d",
                         got.bin_index, got.place_status, got.bins_used));
        return;
      end
      want = expected_q.pop_front();
      if (got.bin_index !== want.bin_index || got.place_status !== want.place_status ||
          got.bins_used !== want.bins_used)
        report($sformatf("mismatch: want bin %0d st %0d used %0d, got bin %0d st %0d used %0d",
                         want.bin_index, want.place_status, want.bins_used,
                         got.bin_index, got.place_status, got.bins_used));
    endfunction

    function void check_leftovers();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  item_t                item_i      = '0;
  logic                 done_o;
  result_t              result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CAP_W-1:0]     cfg_data_i  = '0;
  int                   idle_cycles = 0;
  bin_fit_checker       placements  = new;

  online_bin_fit_allocator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Transfer monitor: results first, then register writes, then items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) placements.check_placement(result_o);
      if (cfg_valid_i && cfg_ready_o) placements.write_reg(cfg_index_i, cfg_data_i);
      if (start && !busy) placements.place_item(item_i);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == CYCLE_LIMIT) begin
      $display("online_bin_fit_allocator_top_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item and hold it until the transfer; start stays high after
  task automatic put_item(input logic [ITEM_W-1:0] size, input logic fresh);
    start  <= 1'b1;
    item_i <= '{item_size: size, new_set: fresh};
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Wait until every placement has been reported and the block is idle
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (placements.expected_q.size() != 0 || busy !== 1'b0);
    @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] data);
    settle();
    repeat ($urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly sizes that fit, some zero, oversize or fully random
  function automatic logic [ITEM_W-1:0] pick_size(input logic [CAP_W-1:0] cap);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 12)
      return (cap == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(int'(cap) + 1, 65535));
    if (roll < 18) return 16'($urandom);
    if (cap == '0) return 16'd1;
    if (roll < 50) return 16'($urandom_range(1, (int'(cap) + 3) / 4));
    return 16'($urandom_range(1, int'(cap)));
  endfunction

  // Phase 0 gets a tiny capacity so that all bins fill up
  function automatic logic [CAP_W-1:0] pick_capacity(input int phase);
    int roll;
    if (phase == 0) return 16'($urandom_range(1, 2));
    roll = $urandom_range(0, 19);
    if (roll < 6)  return 16'($urandom_range(1, 6));
    if (roll < 12) return 16'($urandom_range(7, 300));
    if (roll < 16) return 16'($urandom);
    if (roll < 19) return 16'hFFFF;
    return '0;
  endfunction

  // Mostly back to back or short, now and then long enough to outlast a scan
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 90);
  endfunction

  initial begin
    logic [CAP_W-1:0] cap;
    bit               steady;
    bit               fresh;
    int               set_left;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First fit at reset capacity: zero size, exact fill, oversize, new set
    put_item(16'd0, 1'b0);
    put_item(16'd100, 1'b0);
    put_item(16'd101, 1'b0);
    put_item(16'hFFFF, 1'b0);
    put_item(16'd1, 1'b0);
    put_item(16'd0, 1'b0);
    put_item(16'd50, 1'b1);

    // Best fit: tightest bin wins, lowest index on ties
    set_reg(REG_FIT_MODE, 16'hFFFF);
    put_item(16'd30, 1'b0);
    put_item(16'd60, 1'b0);
    put_item(16'd15, 1'b0);
    put_item(16'd25, 1'b0);

    // Capacity lowered below existing levels; those bins never fit again
    set_reg(REG_BIN_CAPACITY, 16'd50);
    put_item(16'd10, 1'b0);
    set_reg(REG_SPARE_A, 16'h0000);
    set_reg(REG_SPARE_B, 16'hFFFF);
    put_item(16'd50, 1'b0);

    // Zero capacity: anything non-zero is oversize
    set_reg(REG_BIN_CAPACITY, 16'd0);
    put_item(16'd1, 1'b0);
    put_item(16'd0, 1'b1);

    // Full-scale capacity and sizes
    set_reg(REG_BIN_CAPACITY, 16'hFFFF);
    set_reg(REG_FIT_MODE, 16'h0000);
    put_item(16'hFFFF, 1'b1);
    put_item(16'hFFFF, 1'b0);
    put_item(16'h8000, 1'b0);
    put_item(16'h7FFF, 1'b0);

    // Random phases of item sets
    for (int phase = 0; phase < PHASES; phase++) begin
      if ($urandom_range(0, 4) == 0)
        set_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
      set_reg(REG_FIT_MODE, 16'($urandom));
      cap = pick_capacity(phase);
      set_reg(REG_BIN_CAPACITY, cap);
      steady   = ($urandom_range(0, 3) == 0);
      set_left = (phase == 0) ? ITEMS_PER_PHASE : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        fresh = 1'b0;
        if (set_left == 0) begin
          fresh    = 1'b1;
          set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(20, 150);
        end else if ($urandom_range(0, 19) == 0) begin
          // stray new set breaking into a set
          fresh = 1'($urandom_range(0, 1));
        end
        set_left--;
        put_item(pick_size(cap), fresh);
        if (!steady) pause(pick_gap());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    placements.check_leftovers();
    if (placements.fails == 0)
      $display("online_bin_fit_allocator_top_test passed");
    else
      $display("online_bin_fit_allocator_top_test failed");
    $finish;
  end

endmodule
